@@ rtl/core/swm_pkg.sv @@
// Package for the sliding window maximum block.
// Holds sizes, the cell entry and control types, and window arithmetic helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  localparam int WINDOW_MAX   = 64;
  localparam int SAMPLE_WIDTH = 32;
  localparam int CFG_W        = 7;
  localparam int POS_MOD      = 2 * WINDOW_MAX;
  localparam int POS_W        = $clog2(POS_MOD);
  localparam int K_W          = $clog2(WINDOW_MAX + 1);

  typedef struct packed {
    logic                           valid;
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic [POS_W-1:0]               pos;
  } swm_entry_t;

  typedef struct packed {
    logic                           accept;
    logic                           drain;
    logic                           drop;
    logic                           restart;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [POS_W-1:0]               pos;
  } swm_ctl_t;

  typedef struct packed {
    logic prev_keep;
    logic self_keep;
    logic right_keep;
  } swm_link_t;

  function automatic logic [K_W-1:0] effective_k(input logic [CFG_W-1:0] ws);
    logic [K_W-1:0] k;
    if (ws == '0) begin
      k = K_W'(1);
    end else if (int'(ws) > WINDOW_MAX) begin
      k = K_W'(WINDOW_MAX);
    end else begin
      k = K_W'(ws);
    end
    return k;
  endfunction

  function automatic logic is_expired(input logic [POS_W-1:0] pc,
                                      input logic [POS_W-1:0] pos,
                                      input logic [K_W-1:0]   k);
    int age;
    if (pc >= pos) begin
      age = int'(pc) - int'(pos);
    end else begin
      age = int'(pc) + POS_MOD - int'(pos);
    end
    return age >= int'(k);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/swm_cell.sv @@
// One cell of the deque chain: holds one value and position pair.
// Depends on swm_pkg for the entry, control and link types.
`timescale 1ns / 1ps
`default_nettype none

module swm_cell import swm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire swm_ctl_t   ctl,
  input  wire swm_link_t  link,
  input  wire swm_entry_t right,
  output swm_entry_t      entry,
  output swm_entry_t      entry_next,
  output logic            keep
);

  swm_entry_t fresh;

  assign keep = entry.valid && !(entry.value < ctl.sample) && !ctl.restart;

  always_comb begin
    fresh.valid = 1'b1;
    fresh.value = ctl.sample;
    fresh.pos   = ctl.pos;
    entry_next  = entry;
    if (ctl.accept) begin
      if (ctl.drop) begin
        if (link.right_keep) begin
          entry_next = right;
        end else if (link.self_keep) begin
          entry_next = fresh;
        end else begin
          entry_next       = entry;
          entry_next.valid = 1'b0;
        end
      end else begin
        if (keep) begin
          entry_next = entry;
        end else if (link.prev_keep) begin
          entry_next = fresh;
        end else begin
          entry_next       = entry;
          entry_next.valid = 1'b0;
        end
      end
    end else if (ctl.drain) begin
      entry_next = right;
    end
  end

  always_ff @(posedge clk) begin
    entry.value <= entry_next.value;
    entry.pos   <= entry_next.pos;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/swm_outq.sv @@
// Two-entry result queue that decouples the cell chain from the output channel.
// Depends on swm_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

module swm_outq import swm_pkg::*; (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire logic signed [SAMPLE_WIDTH-1:0] push_data,
  output logic                                full,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      out_data
);

  logic [1:0]                     count;
  logic signed [SAMPLE_WIDTH-1:0] head;
  logic signed [SAMPLE_WIDTH-1:0] tail;
  logic                           pop;

  assign pop       = (count != 2'd0) && out_ready;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = head;

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        head <= push_data;
      end else begin
        tail <= push_data;
      end
    end else if (!push && pop) begin
      head <= tail;
    end else if (push && pop) begin
      if (count == 2'd1) begin
        head <= push_data;
      end else begin
        head <= tail;
        tail <= push_data;
      end
    end
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (!push && pop) begin
      count <= count - 2'd1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sliding_window_maximum.sv @@
// Top level of the sliding window maximum block.
// Depends on swm_pkg, swm_cell and swm_outq.
// A sample transaction is taken every cycle unless the input stalls: a chain of WINDOW_MAX cells
// holds the monotonic deque and every cell decides its next contents in parallel. After
// window_size is lowered, stale entries at the front are removed one per cycle before the next
// sample is taken, and the last one is dropped together with that sample. Results pass through
// a two-entry queue; the input stalls while that queue is full or stale entries are removed.
// A result appears once window_size (0 as 1, at most WINDOW_MAX) samples came since restart.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_maximum import swm_pkg::*; (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [CFG_W-1:0]               window_size,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  input  wire logic                           restart,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      window_max
);

  logic [CFG_W-1:0] win_reg;
  logic [K_W-1:0]   k;
  logic [POS_W-1:0] pc;
  logic [K_W-1:0]   fill;
  logic [K_W-1:0]   fill_next;
  logic [K_W:0]     fill_inc;
  logic             accept;
  logic             drain;
  logic             q_full;
  logic             push;
  swm_ctl_t         ctl;

  swm_entry_t               ent     [WINDOW_MAX];
  swm_entry_t               ent_nx  [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]    keep;

  assign cfg_ready = 1'b1;
  assign k         = effective_k(win_reg);

  assign drain = ent[0].valid && is_expired(pc, ent[0].pos, k)
              && ent[1].valid && is_expired(pc, ent[1].pos, k);
  assign in_ready = !drain && !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ctl.accept  = accept;
    ctl.drain   = drain;
    ctl.restart = restart;
    ctl.sample  = sample;
    ctl.pos     = restart ? '0 : pc;
    ctl.drop    = !restart && ent[0].valid && is_expired(pc, ent[0].pos, k);
  end

  always_comb begin
    fill_inc = {1'b0, fill} + (K_W + 1)'(1);
    if (restart) begin
      fill_next = K_W'(1);
    end else if (fill_inc > {1'b0, k}) begin
      fill_next = k;
    end else begin
      fill_next = fill_inc[K_W-1:0];
    end
  end

  assign push = accept && (fill_next >= k);

  genvar i;
  generate
    for (i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swm_link_t  lk;
      swm_entry_t rt;
      if (i == 0) begin : g_first
        assign lk.prev_keep = 1'b1;
        assign lk.self_keep = 1'b1;
      end else begin : g_mid
        assign lk.prev_keep = keep[i-1];
        assign lk.self_keep = keep[i];
      end
      if (i == WINDOW_MAX - 1) begin : g_last
        assign lk.right_keep = 1'b0;
        assign rt            = '0;
      end else begin : g_inner
        assign lk.right_keep = keep[i+1];
        assign rt            = ent[i+1];
      end
      swm_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .link       (lk),
        .right      (rt),
        .entry      (ent[i]),
        .entry_next (ent_nx[i]),
        .keep       (keep[i])
      );
    end
  endgenerate

  swm_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (ent_nx[0].value),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (window_max)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win_reg <= CFG_W'(1);
      pc      <= '0;
      fill    <= '0;
    end else begin
      if (cfg_valid) begin
        win_reg <= window_size;
      end
      if (accept) begin
        fill <= fill_next;
        if (int'(ctl.pos) == POS_MOD - 1) begin
          pc <= '0;
        end else begin
          pc <= ctl.pos + POS_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire
